>>> sv/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types, codes and default sizes for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

    // Default sizing, handed to the top-level parameters.
    localparam int DEF_FRAMES        = 32768;
    localparam int DEF_MAP_WORD_BITS = 32;

    // Fixed field widths of the ports, and the page shift of an address.
    localparam int FNUM_W     = 20;
    localparam int ADDR_W     = 27;
    localparam int LIMIT_W    = 16;
    localparam int PAGE_SHIFT = 12;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32768;

    // Request kinds.
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_type_t;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_ZERO    = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_CHK,
        S_SCAN,
        S_FREE_CHK,
        S_FWALK,
        S_FRMW,
        S_DONE
    } seq_state_t;

endpackage

>>> sv/frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit page-frame allocator over a one-bit-per-frame used map in RAM.
// Allocate: scans map words from word 0, one word per cycle through the RAM
//   read port, until a clear bit is found or the next word would pass the limit.
// Free: walks word by word to the frame's word with the shared adder, then
//   clears its bit; zero and out-of-range frames respond without a walk.
// One request at a time; a new request is taken while a response waits.
// Reset: the map is cleared by a pass over every map word, during which no
//   request is taken.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
    parameter int FRAMES        = fba_pkg::DEF_FRAMES,
    parameter int MAP_WORD_BITS = fba_pkg::DEF_MAP_WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fba_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [fba_pkg::FNUM_W-1:0]    frame_number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [fba_pkg::ADDR_W-1:0]    page_addr
);

    import fba_pkg::*;

    localparam int MAP_DEPTH = (FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 2 * MAP_WORD_BITS + 1);
    localparam int LW        = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    logic [LIMIT_W-1:0]       frame_limit_reg;
    logic [CNT_W-1:0]         managed;
    logic                     ram_wr_en;
    logic [AW-1:0]            ram_wr_addr;
    logic [MAP_WORD_BITS-1:0] ram_wr_data;
    logic [AW-1:0]            ram_rd_addr;
    logic [MAP_WORD_BITS-1:0] ram_rd_data;

    // Frame limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            frame_limit_reg <= cfg_wr_data;
        end
    end

    // Managed frame count saturates at the map size.
    assign managed = (LW'(frame_limit_reg) < LW'(FRAMES)) ? CNT_W'(frame_limit_reg)
                                                          : CNT_W'(FRAMES);

    // Sequencer.
    fba_seq #(
        .FRAMES        (FRAMES),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .MAP_DEPTH     (MAP_DEPTH),
        .AW            (AW),
        .CNT_W         (CNT_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .frame_number (frame_number),
        .managed      (managed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .page_addr    (page_addr),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    // Used map.
    fba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_DEPTH),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // After an accepted request the sequencer is busy in the following cycle.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("request taken while previous one still in flight");

    // The map is only written while a request or the clearing pass is active.
    a_no_write_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> !in_ready
    ) else $error("map written while sequencer idle");

    // Only a successful allocation carries an address.
    a_addr_zero_on_fail: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (page_addr == '0)
    ) else $error("nonzero address on failed request");

endmodule

>>> sv/fba_ram.sv
// ----------------------------------------------------------------------------
// fba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/fba_lowzero.sv
// ----------------------------------------------------------------------------
// fba_lowzero
// Finds the lowest clear bit of one map word.
// ----------------------------------------------------------------------------
module fba_lowzero #(
    parameter int W = 32
) (
    input  logic [W-1:0]         word,
    output logic                 found,
    output logic [$clog2(W)-1:0] idx
);

    // Scan from the top so the lowest clear bit wins.
    always_comb
    begin
        idx = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                idx = ($clog2(W))'(i);
            end
        end
    end

    assign found = ~&word;

endmodule

>>> sv/fba_seq.sv
// ----------------------------------------------------------------------------
// fba_seq
// Request sequencer: clears the map after reset, scans words for allocation,
// walks to the word of a frame on free, and holds the response register.
// ----------------------------------------------------------------------------
module fba_seq #(
    parameter int FRAMES        = fba_pkg::DEF_FRAMES,
    parameter int MAP_WORD_BITS = fba_pkg::DEF_MAP_WORD_BITS,
    parameter int MAP_DEPTH     = (FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    parameter int AW            = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1,
    parameter int CNT_W         = $clog2(FRAMES + 2 * MAP_WORD_BITS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [fba_pkg::FNUM_W-1:0]   frame_number,
    input  logic [CNT_W-1:0]             managed,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [fba_pkg::ADDR_W-1:0]   page_addr,
    output logic                         ram_wr_en,
    output logic [AW-1:0]                ram_wr_addr,
    output logic [MAP_WORD_BITS-1:0]     ram_wr_data,
    output logic [AW-1:0]                ram_rd_addr,
    input  logic [MAP_WORD_BITS-1:0]     ram_rd_data
);

    import fba_pkg::*;

    localparam int BIT_W = $clog2(MAP_WORD_BITS);
    localparam int CW    = (CNT_W > FNUM_W) ? CNT_W : FNUM_W;

    seq_state_t state_reg, state_next;

    logic [AW-1:0]     w_reg, w_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic [FNUM_W-1:0] fnum_reg, fnum_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic [CNT_W-1:0]  add_op;
    logic [CNT_W-1:0]  cmp_op;
    logic [CNT_W-1:0]  sum;
    logic              le;
    logic [CNT_W-1:0]  fnum_c;
    logic              lz_found;
    logic [BIT_W-1:0]  lz_idx;
    logic [CNT_W-1:0]  frame;
    logic [CNT_W+PAGE_SHIFT-1:0] frame_sh;

    // Lowest clear bit of the word coming out of the map.
    fba_lowzero #(
        .W (MAP_WORD_BITS)
    ) u_lowzero (
        .word  (ram_rd_data),
        .found (lz_found),
        .idx   (lz_idx)
    );

    // Shared add-and-compare unit: steps a word boundary by one word and
    // compares it against the limit or the frame.
    assign fnum_c = CNT_W'(fnum_reg);

    always_comb
    begin
        add_op = (state_reg == S_SCAN || state_reg == S_FWALK) ? CNT_W'(MAP_WORD_BITS) : '0;
        cmp_op = (state_reg == S_FWALK) ? fnum_c : managed;
        sum    = end_reg + add_op;
        le     = (sum <= cmp_op);
    end

    // Frame number and address of the bit found in the current word.
    assign frame    = end_reg - CNT_W'(MAP_WORD_BITS) + CNT_W'(lz_idx);
    assign frame_sh = {frame, {PAGE_SHIFT{1'b0}}};

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            w_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg        <= end_next;
        fnum_reg       <= fnum_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
    end

    // Next state, map accesses and response loading.
    always_comb
    begin
        state_next      = state_reg;
        w_next          = w_reg;
        end_next        = end_reg;
        fnum_next       = fnum_reg;
        bit_next        = bit_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = w_reg;
        ram_wr_data     = '0;
        ram_rd_addr     = w_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en = 1'b1;
                if (w_reg == AW'(MAP_DEPTH - 1))
                begin
                    w_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next = w_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    // An allocate tracks the end of the current word, a free its start.
                    w_next          = '0;
                    end_next        = (req_type == REQ_FREE) ? '0 : CNT_W'(MAP_WORD_BITS);
                    fnum_next       = frame_number;
                    res_addr_next   = '0;
                    res_status_next = ST_NO_FREE;
                    state_next      = (req_type == REQ_FREE) ? S_FREE_CHK : S_ALLOC_CHK;
                end
            end

            S_ALLOC_CHK:
            begin
                // The first word must lie wholly below the limit.
                ram_rd_addr = '0;
                state_next  = le ? S_SCAN : S_DONE;
            end

            S_SCAN:
            begin
                ram_rd_addr = w_reg + 1'b1;
                if (lz_found)
                begin
                    ram_wr_en       = 1'b1;
                    ram_wr_data     = ram_rd_data | (MAP_WORD_BITS'(1) << lz_idx);
                    res_status_next = ST_OK;
                    res_addr_next   = ADDR_W'(frame_sh);
                    state_next      = S_DONE;
                end
                else if (le)
                begin
                    w_next   = w_reg + 1'b1;
                    end_next = sum;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FREE_CHK:
            begin
                if (fnum_reg == '0)
                begin
                    res_status_next = ST_ZERO;
                    state_next      = S_DONE;
                end
                else if (CW'(fnum_reg) >= CW'(managed))
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_FWALK;
                end
            end

            S_FWALK:
            begin
                // Step one word at a time until the frame falls inside it.
                if (le)
                begin
                    w_next   = w_reg + 1'b1;
                    end_next = sum;
                end
                else
                begin
                    bit_next   = BIT_W'(fnum_c - end_reg);
                    state_next = S_FRMW;
                end
            end

            S_FRMW:
            begin
                ram_wr_en       = 1'b1;
                ram_wr_data     = ram_rd_data & ~(MAP_WORD_BITS'(1) << bit_reg);
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    addr_next      = res_addr_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign page_addr  = addr_reg;

endmodule

>>> tb/sv/tb_frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_bitmap_allocator
// Self-checking testbench for the first-fit page-frame allocator. A shadow
// used map predicts each response as its request is accepted. Directed edge
// cases come first, then map-full cycles, random traffic under several frame
// limits, a long response hold-off, and a final stream with no idling.
// ----------------------------------------------------------------------------
module tb_frame_bitmap_allocator;

    import fba_pkg::*;

    localparam int FRAMES        = DEF_FRAMES;
    localparam int WORD_BITS     = DEF_MAP_WORD_BITS;
    localparam int MAP_WORDS     = FRAMES / WORD_BITS;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 1100;

    // One predicted response.
    typedef struct packed {
        status_t           st;
        logic [ADDR_W-1:0] addr;
    } frame_reply_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [LIMIT_W-1:0]  cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic                req_type;
    logic [FNUM_W-1:0]   frame_number;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          status;
    logic [ADDR_W-1:0]   page_addr;

    // Shadow copy of the allocator state.
    bit [WORD_BITS-1:0]  used_words [0:MAP_WORDS-1];
    logic [LIMIT_W-1:0]  limit_shadow;

    frame_reply_t        replies_due[$];
    int                  held_frames[$];

    bit                  sender_idling;
    bit                  receiver_idling;
    int                  hold_off_cycles = 0;
    int                  cycle_count = 0;
    int                  error_count = 0;

    int                  n_requests = 0;
    int                  n_handed = 0;
    int                  n_refused = 0;
    int                  n_released = 0;
    int                  n_zero = 0;
    int                  n_range = 0;
    int                  n_limits = 0;

    frame_bitmap_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .frame_number (frame_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .page_addr    (page_addr)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Frames under management; the count saturates at the map size.
    function automatic int managed_frames();
        return (int'(limit_shadow) < FRAMES) ? int'(limit_shadow) : FRAMES;
    endfunction

    // Apply one request to the shadow map and return its response.
    function automatic frame_reply_t serve_request(input req_type_t kind,
                                                   input logic [FNUM_W-1:0] fnum);
        frame_reply_t reply;
        int           managed;
        int           frame;
        bit           found;
        reply.st   = ST_NO_FREE;
        reply.addr = '0;
        managed    = managed_frames();
        frame      = int'(fnum);
        found      = 1'b0;
        if (kind == REQ_ALLOC)
        begin
            // First fit over whole words below the managed count.
            for (int w = 0; w < managed / WORD_BITS && !found; w++)
            begin
                for (int b = 0; b < WORD_BITS && !found; b++)
                begin
                    if (!used_words[w][b])
                    begin
                        used_words[w][b] = 1'b1;
                        reply.addr = ADDR_W'((w * WORD_BITS + b) << PAGE_SHIFT);
                        reply.st   = ST_OK;
                        found      = 1'b1;
                    end
                end
            end
            if (found)
                n_handed++;
            else
                n_refused++;
        end
        else if (frame == 0)
        begin
            reply.st = ST_ZERO;
            n_zero++;
        end
        else if (frame >= managed)
        begin
            reply.st = ST_RANGE;
            n_range++;
        end
        else
        begin
            used_words[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
            reply.st = ST_OK;
            n_released++;
        end
        return reply;
    endfunction

    // Offer one request, wait for it to be taken, then record its response.
    task automatic send_request(input req_type_t kind, input logic [FNUM_W-1:0] fnum);
        int           gap;
        frame_reply_t reply;
        gap = 0;
        if (sender_idling && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        frame_number <= fnum;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        reply = serve_request(kind, fnum);
        replies_due.push_back(reply);
        n_requests++;
        if (kind == REQ_ALLOC && reply.st == ST_OK)
            held_frames.push_back(int'(reply.addr >> PAGE_SHIFT));
    endtask

    // Withdraw the request line and wait until every response is back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
    endtask

    // Write the frame limit once the allocator has gone quiet.
    task automatic set_frame_limit(input logic [LIMIT_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        limit_shadow = value;
        n_limits++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly allocations and frees of held frames, with some stray frees.
    task automatic random_mix(input int count);
        int                pick;
        int                idx;
        int                managed;
        logic [FNUM_W-1:0] fnum;
        repeat (count)
        begin
            pick    = $urandom_range(0, 99);
            managed = managed_frames();
            fnum    = FNUM_W'($urandom);
            if (pick < 58 || (pick < 88 && held_frames.size() == 0))
                send_request(REQ_ALLOC, fnum);
            else if (pick < 88)
            begin
                idx  = $urandom_range(0, held_frames.size() - 1);
                fnum = FNUM_W'(held_frames[idx]);
                held_frames.delete(idx);
                send_request(REQ_FREE, fnum);
            end
            else
            begin
                // Stray frees: zero, anything, the boundary, or any frame in range.
                case ($urandom_range(0, 4))
                    0: fnum = '0;
                    1: fnum = FNUM_W'($urandom);
                    2: fnum = FNUM_W'(managed);
                    3: if (managed > 0) fnum = FNUM_W'(managed - 1);
                    default: if (managed > 1) fnum = FNUM_W'($urandom_range(1, managed - 1));
                endcase
                send_request(REQ_FREE, fnum);
            end
        end
    endtask

    // Operations, frame zero, range edges, saturation, small limits and a partial word.
    task automatic test_directed_edges();
        send_request(REQ_ALLOC, '1);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 20'd0);
        send_request(REQ_FREE, 20'd1);
        send_request(REQ_FREE, 20'd1);
        send_request(REQ_FREE, 20'd32767);
        send_request(REQ_FREE, 20'd32768);
        send_request(REQ_FREE, 20'hFFFFF);
        send_request(REQ_ALLOC, 20'h5A5A5);
        set_frame_limit(16'hFFFF);
        send_request(REQ_FREE, 20'd32768);
        send_request(REQ_FREE, 20'd32767);
        send_request(REQ_ALLOC, 20'hA5A5A);
        set_frame_limit(16'd0);
        send_request(REQ_ALLOC, 20'd0);
        send_request(REQ_FREE, 20'd0);
        send_request(REQ_FREE, 20'd1);
        set_frame_limit(16'd31);
        send_request(REQ_ALLOC, 20'd7);
        send_request(REQ_FREE, 20'd30);
        send_request(REQ_FREE, 20'd31);
        set_frame_limit(16'd40);
        send_request(REQ_FREE, 20'd39);
        send_request(REQ_FREE, 20'd40);
        send_request(REQ_ALLOC, 20'd0);
        send_request(REQ_FREE, 20'd2);
        send_request(REQ_ALLOC, 20'd0);
    endtask

    // Fill a one-word map until it refuses, release half, and repeat.
    task automatic test_map_full();
        int                refusals;
        int                idx;
        logic [FNUM_W-1:0] fnum;
        set_frame_limit(16'd32);
        repeat (3)
        begin
            refusals = 0;
            while (refusals < 2)
            begin
                send_request(REQ_ALLOC, FNUM_W'($urandom));
                if (replies_due[$].st == ST_NO_FREE)
                    refusals++;
            end
            repeat (held_frames.size() / 2)
            begin
                idx  = $urandom_range(0, held_frames.size() - 1);
                fnum = FNUM_W'(held_frames[idx]);
                held_frames.delete(idx);
                send_request(REQ_FREE, fnum);
            end
        end
    endtask

    // Random traffic under a spread of frame limits.
    task automatic test_random_phases();
        int                 p;
        logic [LIMIT_W-1:0] lim;
        for (p = 0; p < 6; p++)
        begin
            case (p)
                0: lim = 16'd64;
                1: lim = LIMIT_W'($urandom_range(33, 200));
                2: lim = LIMIT_W'(FRAMES);
                3: lim = LIMIT_W'($urandom_range(201, 2048));
                4: lim = 16'hFFFF;
                default: lim = LIMIT_W'($urandom);
            endcase
            set_frame_limit(lim);
            random_mix(55);
        end
    endtask

    // Hold responses off long enough that the allocator stops taking requests.
    task automatic test_backpressure();
        set_frame_limit(16'd256);
        sender_idling   = 1'b0;
        hold_off_cycles = 400;
        random_mix(14);
        sender_idling   = 1'b1;
        wait_drained();
    endtask

    // Back-to-back traffic with both sides always ready.
    task automatic test_steady_stream();
        set_frame_limit(16'd96);
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        random_mix(80);
    endtask

    // Response side: random stalls, plus the long hold-off when one is asked for.
    initial
    begin : response_sink
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (receiver_idling && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk)
    begin : reply_check
        frame_reply_t due;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (replies_due.size() == 0)
            begin
                error_count++;
                $display("%0t: response with no request outstanding: expected none,",
                         $time);
                $display("    got status %0d page_addr 0x%0h", status, page_addr);
            end
            else
            begin
                due = replies_due.pop_front();
                if (status !== due.st)
                begin
                    error_count++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, due.st, status);
                end
                if (page_addr !== due.addr)
                begin
                    error_count++;
                    $display("%0t: page_addr mismatch: expected 0x%0h, got 0x%0h",
                             $time, due.addr, page_addr);
                end
            end
        end
    end

    // Test sequence.
    initial
    begin : regression
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        req_type        = REQ_ALLOC;
        frame_number    = '0;
        limit_shadow    = LIMIT_RESET;
        sender_idling   = 1'b1;
        receiver_idling = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_map_full();
        test_random_phases();
        test_backpressure();
        test_steady_stream();

        // Drain, then watch for stray responses.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            error_count++;
            $display("%0t: responses still outstanding: expected 0, got %0d",
                     $time, replies_due.size());
        end

        $display("Ran %0d requests across %0d frame-limit writes, with idling,",
                 n_requests, n_limits);
        $display("a long hold-off and a back-to-back stream.");
        $display("Frames handed out %0d, refused when full %0d, released %0d,",
                 n_handed, n_refused, n_released);
        $display("zero frees %0d, out of range %0d.", n_zero, n_range);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
